// ----- src/spa_pkg.sv -----
// spa_pkg: shared constants, types and field conversions for the sparse polynomial adder
// no dependencies; imported by spa_cell, spa_chain and sparse_polynomial_adder_core
package spa_pkg;

    // table depth and internal arithmetic widths
    localparam int TERMS_PER_POLY = 16;
    localparam int COEF_WIDTH     = 32;
    localparam int EXP_WIDTH      = 16;

    // fixed widths of the stream fields
    localparam int PORT_COEF_W = 32;
    localparam int PORT_EXP_W  = 16;
    localparam int CMD_W       = 2;
    localparam int DATA_W      = PORT_COEF_W + PORT_EXP_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMBINE = 2'd2;

    // one stored term
    typedef struct packed {
        logic                  valid;
        logic [COEF_WIDTH-1:0] coef;
        logic [EXP_WIDTH-1:0]  expo;
    } t_term;

    // per-cycle control of one cell row
    typedef struct packed {
        logic ins;
        logic pop;
    } t_chain_ctl;

    // low bits of a port field, zero-extended if the internal width is larger
    function automatic logic [COEF_WIDTH-1:0] coef_from_port(input logic [PORT_COEF_W-1:0] p);
        logic [COEF_WIDTH-1:0] c;
        c = '0;
        for (int i = 0; i < COEF_WIDTH && i < PORT_COEF_W; i++) c[i] = p[i];
        return c;
    endfunction

    function automatic logic [PORT_COEF_W-1:0] coef_to_port(input logic [COEF_WIDTH-1:0] c);
        logic [PORT_COEF_W-1:0] p;
        p = '0;
        for (int i = 0; i < COEF_WIDTH && i < PORT_COEF_W; i++) p[i] = c[i];
        return p;
    endfunction

    function automatic logic [EXP_WIDTH-1:0] exp_from_port(input logic [PORT_EXP_W-1:0] p);
        logic [EXP_WIDTH-1:0] e;
        e = '0;
        for (int i = 0; i < EXP_WIDTH && i < PORT_EXP_W; i++) e[i] = p[i];
        return e;
    endfunction

    function automatic logic [PORT_EXP_W-1:0] exp_to_port(input logic [EXP_WIDTH-1:0] e);
        logic [PORT_EXP_W-1:0] p;
        p = '0;
        for (int i = 0; i < EXP_WIDTH && i < PORT_EXP_W; i++) p[i] = e[i];
        return p;
    endfunction

endpackage

// ----- src/spa_cell.sv -----
// spa_cell: one slot of a sorted term row, inserting or shifting
// depends on spa_pkg
module spa_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spa_pkg::t_chain_ctl i_ctl,
    input  spa_pkg::t_term     i_new,
    input  spa_pkg::t_term     i_left,
    input  logic               i_left_m,
    input  spa_pkg::t_term     i_right,
    output spa_pkg::t_term     o_term,
    output logic               o_m
);
    import spa_pkg::*;

    logic                  r_valid;
    logic [COEF_WIDTH-1:0] r_coef;
    logic [EXP_WIDTH-1:0]  r_expo;
    logic                  n_valid;
    logic [COEF_WIDTH-1:0] n_coef;
    logic [EXP_WIDTH-1:0]  n_expo;

    // set when the new term goes at or before this slot
    assign o_m = !r_valid || ($signed(r_expo) >= $signed(i_new.expo));

    always_comb begin
        n_valid = r_valid;
        n_coef  = r_coef;
        n_expo  = r_expo;
        if (i_ctl.pop) begin
            n_valid = i_right.valid;
            n_coef  = i_right.coef;
            n_expo  = i_right.expo;
        end else if (i_ctl.ins) begin
            if (i_left_m) begin
                n_valid = i_left.valid;
                n_coef  = i_left.coef;
                n_expo  = i_left.expo;
            end else if (o_m) begin
                n_valid = 1'b1;
                n_coef  = i_new.coef;
                n_expo  = i_new.expo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= n_coef;
        r_expo <= n_expo;
    end

    assign o_term = '{valid: r_valid, coef: r_coef, expo: r_expo};

endmodule

// ----- src/spa_chain.sv -----
// spa_chain: row of spa_cell slots holding one term table in ascending exponent order
// depends on spa_pkg and spa_cell
module spa_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spa_pkg::t_chain_ctl i_ctl,
    input  spa_pkg::t_term      i_new,
    output spa_pkg::t_term      o_head,
    output logic                o_full
);
    import spa_pkg::*;

    t_term cell_term [TERMS_PER_POLY];
    logic  cell_m    [TERMS_PER_POLY];

    for (genvar g = 0; g < TERMS_PER_POLY; g++) begin : g_cell
        t_term left_term;
        t_term right_term;
        logic  left_m;

        if (g == 0) begin : g_first
            assign left_term = '0;
            assign left_m    = 1'b0;
        end else begin : g_mid
            assign left_term = cell_term[g-1];
            assign left_m    = cell_m[g-1];
        end

        if (g == TERMS_PER_POLY - 1) begin : g_last
            assign right_term = '0;
        end else begin : g_inner
            assign right_term = cell_term[g+1];
        end

        spa_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (i_ctl),
            .i_new    (i_new),
            .i_left   (left_term),
            .i_left_m (left_m),
            .i_right  (right_term),
            .o_term   (cell_term[g]),
            .o_m      (cell_m[g])
        );
    end

    assign o_head = cell_term[0];
    assign o_full = cell_term[TERMS_PER_POLY-1].valid;

endmodule

// ----- src/sparse_polynomial_adder_core.sv -----
// sparse_polynomial_adder_core: top level, two sorted term rows and the merge sequencer
// depends on spa_pkg and spa_chain
//
// Loads (command 0 into table A, 1 into table B) are taken one per cycle while idle: each
// table is a row of cells that finds the insertion slot and shifts the tail right in the same
// cycle, so a term lands ahead of stored terms with an equal or larger exponent. A load into
// a full table is dropped and raises the overflowed flag for the next run. A combine
// (command 2) compares the two row heads and, on equal exponents, adds them with saturation,
// once per cycle while the output register is free; both rows shift toward the head as they
// are consumed, leaving them empty at the end. Results come out in ascending exponent order,
// at most one per cycle; matched pairs that sum to zero give no result, and an empty sum
// gives one result flagged is_empty. No input is taken while a combine runs; a final result
// waiting in the output register does not hold off the next load. Command 3 is accepted and
// ignored.
module sparse_polynomial_adder_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request in
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [spa_pkg::DATA_W-1:0] i_s_tdata,  // coefficient[31:0], exponent[47:32]
    input  logic [spa_pkg::CMD_W-1:0]  i_s_tuser,  // command[1:0]
    // request out
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [spa_pkg::DATA_W-1:0] o_m_tdata,  // sum_coefficient[31:0], sum_exponent[47:32]
    output logic [1:0]                 o_m_tuser,  // is_empty[0], overflowed[1]
    output logic                       o_m_tlast   // last_term
);
    import spa_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_MERGE = 1'b1;

    // saturating add at the coefficient width
    function automatic logic [COEF_WIDTH-1:0] sat_add(input logic [COEF_WIDTH-1:0] a,
                                                      input logic [COEF_WIDTH-1:0] b);
        logic [COEF_WIDTH-1:0] s;
        s = a + b;
        if ((a[COEF_WIDTH-1] == b[COEF_WIDTH-1]) && (s[COEF_WIDTH-1] != a[COEF_WIDTH-1])) begin
            s = a[COEF_WIDTH-1] ? {1'b1, {(COEF_WIDTH-1){1'b0}}}
                                : {1'b0, {(COEF_WIDTH-1){1'b1}}};
        end
        return s;
    endfunction

    logic r_state, n_state;
    logic r_ovf, n_ovf;

    // one merged term held back so the last one can be flagged
    logic                  r_pend_valid, n_pend_valid;
    logic [COEF_WIDTH-1:0] r_pend_coef, n_pend_coef;
    logic [EXP_WIDTH-1:0]  r_pend_expo, n_pend_expo;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [COEF_WIDTH-1:0] r_out_coef, n_out_coef;
    logic [EXP_WIDTH-1:0]  r_out_expo, n_out_expo;
    logic                  r_out_empty, n_out_empty;
    logic                  r_out_ovf, n_out_ovf;
    logic                  r_out_last, n_out_last;

    logic                  in_take;
    logic [CMD_W-1:0]      in_cmd;
    t_term                 new_term;
    t_term                 head_a, head_b;
    logic                  full_a, full_b;
    t_chain_ctl            ctl_a, ctl_b;

    logic                  out_free;
    logic                  step;
    logic                  any_head;
    logic                  cand_valid;
    logic [COEF_WIDTH-1:0] cand_coef;
    logic [EXP_WIDTH-1:0]  cand_expo;
    logic                  pop_a, pop_b;
    logic [COEF_WIDTH-1:0] pair_sum;

    assign o_s_tready = (r_state == ST_IDLE);
    assign in_take    = i_s_tvalid && o_s_tready;
    assign in_cmd     = i_s_tuser;

    assign new_term = '{valid: 1'b1,
                        coef:  coef_from_port(i_s_tdata[PORT_COEF_W-1:0]),
                        expo:  exp_from_port(i_s_tdata[DATA_W-1:PORT_COEF_W])};

    // the output register can take a result this cycle
    assign out_free = !r_out_valid || i_m_tready;
    assign step     = (r_state == ST_MERGE) && out_free;
    assign any_head = head_a.valid || head_b.valid;
    assign pair_sum = sat_add(head_a.coef, head_b.coef);

    // head compare: matched pair, else the smaller exponent goes first
    always_comb begin
        cand_valid = 1'b0;
        cand_coef  = head_b.coef;
        cand_expo  = head_b.expo;
        pop_a      = 1'b0;
        pop_b      = 1'b0;
        priority if (head_a.valid && head_b.valid && (head_a.expo == head_b.expo)) begin
            cand_valid = (pair_sum != '0);
            cand_coef  = pair_sum;
            cand_expo  = head_a.expo;
            pop_a      = 1'b1;
            pop_b      = 1'b1;
        end else if (head_a.valid &&
                     (!head_b.valid || ($signed(head_a.expo) < $signed(head_b.expo)))) begin
            cand_valid = 1'b1;
            cand_coef  = head_a.coef;
            cand_expo  = head_a.expo;
            pop_a      = 1'b1;
        end else if (head_b.valid) begin
            cand_valid = 1'b1;
            pop_b      = 1'b1;
        end else begin
            cand_valid = 1'b0;
        end
    end

    always_comb begin
        ctl_a.ins = in_take && (in_cmd == CMD_LOAD_A) && !full_a;
        ctl_b.ins = in_take && (in_cmd == CMD_LOAD_B) && !full_b;
        ctl_a.pop = step && pop_a;
        ctl_b.pop = step && pop_b;
    end

    always_comb begin
        n_state      = r_state;
        n_ovf        = r_ovf;
        n_pend_valid = r_pend_valid;
        n_pend_coef  = r_pend_coef;
        n_pend_expo  = r_pend_expo;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_coef   = r_out_coef;
        n_out_expo   = r_out_expo;
        n_out_empty  = r_out_empty;
        n_out_ovf    = r_out_ovf;
        n_out_last   = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    // dropped load into a full table
                    if (((in_cmd == CMD_LOAD_A) && full_a) ||
                        ((in_cmd == CMD_LOAD_B) && full_b)) begin
                        n_ovf = 1'b1;
                    end
                    if (in_cmd == CMD_COMBINE) begin
                        n_state = ST_MERGE;
                    end
                end
            end
            ST_MERGE: begin
                if (step) begin
                    if (any_head) begin
                        if (cand_valid) begin
                            if (r_pend_valid) begin
                                n_out_valid = 1'b1;
                                n_out_coef  = r_pend_coef;
                                n_out_expo  = r_pend_expo;
                                n_out_empty = 1'b0;
                                n_out_ovf   = r_ovf;
                                n_out_last  = 1'b0;
                            end
                            n_pend_valid = 1'b1;
                            n_pend_coef  = cand_coef;
                            n_pend_expo  = cand_expo;
                        end
                    end else begin
                        // both rows drained: flush held term or report an empty sum
                        n_out_valid  = 1'b1;
                        n_out_coef   = r_pend_valid ? r_pend_coef : '0;
                        n_out_expo   = r_pend_valid ? r_pend_expo : '0;
                        n_out_empty  = !r_pend_valid;
                        n_out_ovf    = r_ovf;
                        n_out_last   = 1'b1;
                        n_pend_valid = 1'b0;
                        n_ovf        = 1'b0;
                        n_state      = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ovf        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ovf        <= n_ovf;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_coef <= n_pend_coef;
        r_pend_expo <= n_pend_expo;
        r_out_coef  <= n_out_coef;
        r_out_expo  <= n_out_expo;
        r_out_empty <= n_out_empty;
        r_out_ovf   <= n_out_ovf;
        r_out_last  <= n_out_last;
    end

    spa_chain u_chain_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_a),
        .i_new   (new_term),
        .o_head  (head_a),
        .o_full  (full_a)
    );

    spa_chain u_chain_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_b),
        .i_new   (new_term),
        .o_head  (head_b),
        .o_full  (full_b)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {exp_to_port(r_out_expo), coef_to_port(r_out_coef)};
    assign o_m_tuser  = {r_out_ovf, r_out_empty};
    assign o_m_tlast  = r_out_last;

endmodule
